/* rtl/gzhp_pkg.sv */
// Package for the gzip header parser: item and result types and magic byte values.
// No dependencies; used by the front, queue and back modules.
`default_nettype none

package gzhp_pkg;

   localparam logic [7:0] MAGIC_ID1     = 8'h1F;
   localparam logic [7:0] MAGIC_ID2     = 8'h8B;
   localparam logic [7:0] MAGIC_ID2_OLD = 8'h9E;

   typedef struct packed {
      logic       restart;
      logic [7:0] data_byte;
      logic       byte_zero;
      logic       is_id1;
      logic       is_id2;
      logic       is_id2_old;
   } token_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       header_done;
      logic [7:0] method_code;
      logic [3:0] error_bits;
   } result_type;

endpackage

`default_nettype wire

/* rtl/gzhp_if.sv */
// Channel interfaces of the gzip header parser: byte input, result output, register write.
// No dependencies.
`default_nettype none

interface gzhp_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   modport source (output valid, kind, data_byte, input ready);
   modport sink (input valid, kind, data_byte, output ready);
endinterface

interface gzhp_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic       header_done;
   logic [7:0] method_code;
   logic [3:0] error_bits;
   modport source (output valid, payload_valid, payload_byte, header_done, method_code,
                   error_bits, input ready);
   modport sink (input valid, payload_valid, payload_byte, header_done, method_code,
                 error_bits, output ready);
endinterface

interface gzhp_csr_if;
   logic valid;
   logic ready;
   logic write_data;
   modport source (output valid, write_data, input ready);
   modport sink (input valid, write_data, output ready);
endinterface

`default_nettype wire

/* rtl/gzhp_front.sv */
// Front end: accepts input items and classifies each byte against the magic values.
// Depends on gzhp_pkg and gzhp_req_if; feeds gzhp_queue.
`default_nettype none

module gzhp_front
   import gzhp_pkg::*;
(
   gzhp_req_if.sink   req_bus,
   input  logic       queue_full,
   output logic       push,
   output token_type  push_token
);

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   always_comb begin
      push_token.restart    = req_bus.kind;
      push_token.data_byte  = req_bus.data_byte;
      push_token.byte_zero  = (req_bus.data_byte == 8'h00);
      push_token.is_id1     = (req_bus.data_byte == MAGIC_ID1);
      push_token.is_id2     = (req_bus.data_byte == MAGIC_ID2);
      push_token.is_id2_old = (req_bus.data_byte == MAGIC_ID2_OLD);
   end

endmodule

`default_nettype wire

/* rtl/gzhp_queue.sv */
// Short register queue of classified items between the front and back ends.
// Depends on gzhp_pkg.
`default_nettype none

module gzhp_queue
   import gzhp_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_token,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output token_type head_token
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   token_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_token = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop)) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

/* rtl/gzhp_back.sv */
// Back end: header parse state machine, old-magic register and registered result.
// Depends on gzhp_pkg, gzhp_rsp_if and gzhp_csr_if; drained from gzhp_queue.
`default_nettype none

module gzhp_back
   import gzhp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   gzhp_csr_if.sink  csr_bus,
   gzhp_rsp_if.source rsp_bus,
   input  logic      head_valid,
   input  token_type head_token,
   output logic      pop
);

   localparam logic [3:0] PH_MAGIC0  = 4'd0;
   localparam logic [3:0] PH_MAGIC1  = 4'd1;
   localparam logic [3:0] PH_METHOD  = 4'd2;
   localparam logic [3:0] PH_FLAGS   = 4'd3;
   localparam logic [3:0] PH_FIXED   = 4'd4;
   localparam logic [3:0] PH_XLEN_LO = 4'd5;
   localparam logic [3:0] PH_XLEN_HI = 4'd6;
   localparam logic [3:0] PH_XDATA   = 4'd7;
   localparam logic [3:0] PH_NAME    = 4'd8;
   localparam logic [3:0] PH_COMMENT = 4'd9;
   localparam logic [3:0] PH_PAYLOAD = 4'd10;
   localparam logic [3:0] PH_BAD     = 4'd11;

   localparam int FL_CONT    = 1;
   localparam int FL_EXTRA   = 2;
   localparam int FL_NAME    = 3;
   localparam int FL_COMMENT = 4;
   localparam int FL_ENCRYPT = 5;

   localparam logic [15:0] FIXED_SKIP = 16'd6;

   logic        old_magic_ff;
   logic [3:0]  phase_ff, phase_in;
   logic        first_ok_ff, first_ok_in;
   logic [7:0]  flags_ff, flags_in;
   logic [7:0]  method_ff, method_in;
   logic [15:0] skip_ff, skip_in;
   logic [3:0]  error_ff, error_in;
   logic        rsp_valid_ff;
   result_type  rsp_ff, rsp_in;
   logic [15:0] skip_dec;
   logic [15:0] xlen;

   function automatic logic [3:0] after_name(input logic [7:0] fl);
      return fl[FL_COMMENT] ? PH_COMMENT : PH_PAYLOAD;
   endfunction

   function automatic logic [3:0] after_extra(input logic [7:0] fl);
      return fl[FL_NAME] ? PH_NAME : after_name(fl);
   endfunction

   assign csr_bus.ready = 1'b1;
   assign pop           = head_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign skip_dec      = skip_ff - 16'd1;
   assign xlen          = {head_token.data_byte, skip_ff[7:0]};

   always_comb begin
      phase_in    = phase_ff;
      first_ok_in = first_ok_ff;
      flags_in    = flags_ff;
      method_in   = method_ff;
      skip_in     = skip_ff;
      error_in    = error_ff;
      rsp_in      = '0;
      if (head_token.restart) begin
         phase_in    = PH_MAGIC0;
         first_ok_in = 1'b0;
         flags_in    = '0;
         method_in   = '0;
         skip_in     = '0;
         error_in    = '0;
      end else begin
         case (phase_ff)
            PH_MAGIC0: begin
               first_ok_in = head_token.is_id1;
               phase_in    = PH_MAGIC1;
            end
            PH_MAGIC1: begin
               if (first_ok_ff &&
                   (head_token.is_id2 || (old_magic_ff && head_token.is_id2_old))) begin
                  phase_in = PH_METHOD;
               end else begin
                  error_in[3] = 1'b1;
                  phase_in    = PH_BAD;
               end
            end
            PH_METHOD: begin
               method_in = head_token.data_byte;
               phase_in  = PH_FLAGS;
            end
            PH_FLAGS: begin
               flags_in    = head_token.data_byte;
               error_in[0] = error_ff[0] | head_token.data_byte[FL_ENCRYPT];
               error_in[1] = error_ff[1] | head_token.data_byte[FL_CONT];
               error_in[2] = error_ff[2] | (|head_token.data_byte[7:6]);
               skip_in     = FIXED_SKIP;
               phase_in    = PH_FIXED;
            end
            PH_FIXED: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = flags_ff[FL_EXTRA] ? PH_XLEN_LO : after_extra(flags_ff);
               end
            end
            PH_XLEN_LO: begin
               skip_in  = {8'h00, head_token.data_byte};
               phase_in = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
               skip_in  = xlen;
               phase_in = (xlen == '0) ? after_extra(flags_ff) : PH_XDATA;
            end
            PH_XDATA: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = after_extra(flags_ff);
               end
            end
            PH_NAME: begin
               if (head_token.byte_zero) begin
                  phase_in = after_name(flags_ff);
               end
            end
            PH_COMMENT: begin
               if (head_token.byte_zero) begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               rsp_in.payload_valid = 1'b1;
               rsp_in.payload_byte  = head_token.data_byte;
            end
            default: begin
               phase_in = PH_BAD;
            end
         endcase
      end
      rsp_in.header_done = (phase_in == PH_PAYLOAD);
      rsp_in.method_code = method_in;
      rsp_in.error_bits  = error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         old_magic_ff <= 1'b1;
         phase_ff     <= PH_MAGIC0;
         first_ok_ff  <= 1'b0;
         flags_ff     <= '0;
         method_ff    <= '0;
         skip_ff      <= '0;
         error_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            old_magic_ff <= csr_bus.write_data;
         end
         if (pop) begin
            phase_ff    <= phase_in;
            first_ok_ff <= first_ok_in;
            flags_ff    <= flags_in;
            method_ff   <= method_in;
            skip_ff     <= skip_in;
            error_ff    <= error_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.payload_valid = rsp_ff.payload_valid;
   assign rsp_bus.payload_byte  = rsp_ff.payload_byte;
   assign rsp_bus.header_done   = rsp_ff.header_done;
   assign rsp_bus.method_code   = rsp_ff.method_code;
   assign rsp_bus.error_bits    = rsp_ff.error_bits;

   a_bad_has_error: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BAD) |-> error_ff[3]) else $error("bad phase without magic error");
   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FIXED || phase_ff == PH_XDATA) |-> (skip_ff != '0))
      else $error("skip phase with zero count");
   a_payload_after_header: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.payload_valid) |-> rsp_ff.header_done)
      else $error("payload before header done");
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && head_token.restart) |=> (phase_ff == PH_MAGIC0 && rsp_ff == '0))
      else $error("restart did not clear parse state");

endmodule

`default_nettype wire

/* rtl/gzip_header_parser_unit.sv */
// gzip member header parser: strips the member header from a byte stream and passes payload.
// One result per input item. Up to one item per cycle is taken while the queue is not full;
// each item is held in the QUEUE_DEPTH-entry queue and then in the result register.
// Depends on gzhp_pkg, the gzhp interfaces, gzhp_front, gzhp_queue and gzhp_back.
`default_nettype none

module gzip_header_parser_unit
   import gzhp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic       clock,
   input  logic       reset,
   gzhp_req_if.sink   req_bus,
   gzhp_rsp_if.source rsp_bus,
   gzhp_csr_if.sink   csr_bus
);

   logic      queue_full;
   logic      push;
   token_type push_token;
   logic      pop;
   logic      head_valid;
   token_type head_token;

   gzhp_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_token (push_token)
   );

   gzhp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_token (head_token)
   );

   gzhp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_bus    (csr_bus),
      .rsp_bus    (rsp_bus),
      .head_valid (head_valid),
      .head_token (head_token),
      .pop        (pop)
   );

endmodule

`default_nettype wire
